// File: rtl/core/tcga_pkg.sv
// Shared types, constants and helper functions for the text cursor glyph address block.
package tcga_pkg;

    // Default glyph cell size in pixels
    localparam int DEF_CHAR_HEIGHT = 8;
    localparam int DEF_CHAR_WIDTH  = 8;

    // Register file
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_WRAP_ENABLE   = 2'd0,
        REG_X_LIMIT       = 2'd1,
        REG_Y_LIMIT       = 2'd2,
        REG_FONTS_PRESENT = 2'd3
    } t_reg_idx;

    localparam logic       RST_WRAP_ENABLE   = 1'b0;
    localparam logic [9:0] RST_X_LIMIT       = 10'd464;
    localparam logic [9:0] RST_Y_LIMIT       = 10'd256;
    localparam logic [2:0] RST_FONTS_PRESENT = 3'd7;

    // Font present bits
    localparam int FONT_ASCII = 0;
    localparam int FONT_KANA  = 1;
    localparam int FONT_KANJI = 2;

    // Byte codes
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] ASCII_END    = 8'h80;
    localparam logic [7:0] KANA_FIRST   = 8'hA1;
    localparam logic [7:0] KANA_LAST    = 8'hDF;
    localparam logic [7:0] LEAD1_FIRST  = 8'h81;
    localparam logic [7:0] LEAD1_LAST   = 8'h9F;
    localparam logic [7:0] LEAD2_FIRST  = 8'hE0;
    localparam logic [7:0] LEAD2_LAST   = 8'hFC;
    localparam logic [7:0] LEAD2_BASE   = 8'hC1;
    localparam logic [7:0] TRAIL_FIRST  = 8'h40;
    localparam logic [7:0] TRAIL_LAST   = 8'hFC;
    localparam logic [7:0] TRAIL_GAP    = 8'h7E;
    localparam logic [7:0] KU_HALF      = 8'h5E;
    localparam logic [6:0] KU_PER_ROW   = 7'd94;
    localparam logic [6:0] KU_LAST_ROW  = 7'd83;

    localparam int GLYPH_OFF_W = 17;

    typedef enum logic [1:0] {
        SRC_ASCII   = 2'd0,
        SRC_KANA    = 2'd1,
        SRC_KANJI   = 2'd2,
        SRC_MISSING = 2'd3
    } t_glyph_src;

    typedef struct packed {
        logic                wrap_enable;
        logic [9:0]          x_limit;
        logic [9:0]          y_limit;
        logic [2:0]          fonts_present;
    } t_cfg;

    typedef struct packed {
        logic [7:0]          text_byte;
        logic                first_byte;
        logic                last_byte;
        logic signed [15:0]  start_x;
        logic signed [15:0]  start_y;
    } t_in_item;

    typedef struct packed {
        logic                   draw;
        t_glyph_src             glyph_source;
        logic [GLYPH_OFF_W-1:0] glyph_offset;
        logic signed [15:0]     pos_x;
        logic signed [15:0]     pos_y;
        logic [15:0]            char_count;
        logic                   end_of_string;
    } t_out_item;

    // Add a non-negative step, saturating at the positive 16-bit limit
    function automatic logic signed [15:0] sat_add16(logic signed [15:0] a, logic [15:0] b);
        logic [15:0] s;
        s = a + b;
        if (!a[15] && s[15]) begin
            return 16'sh7FFF;
        end
        return s;
    endfunction

    // Signed cursor strictly above an unsigned limit
    function automatic logic over_limit(logic signed [15:0] v, logic [9:0] lim);
        return !v[15] && (v > {6'd0, lim});
    endfunction

endpackage

// File: rtl/core/tcga_cfg.sv
// APB register file for the wrap, limit and font-present settings.
module tcga_cfg
    import tcga_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr;

    assign idx    = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wrap_enable   <= RST_WRAP_ENABLE;
            r_cfg.x_limit       <= RST_X_LIMIT;
            r_cfg.y_limit       <= RST_Y_LIMIT;
            r_cfg.fonts_present <= RST_FONTS_PRESENT;
        end else if (wr) begin
            case (idx)
                REG_WRAP_ENABLE:   r_cfg.wrap_enable   <= pwdata[0];
                REG_X_LIMIT:       r_cfg.x_limit       <= pwdata[9:0];
                REG_Y_LIMIT:       r_cfg.y_limit       <= pwdata[9:0];
                REG_FONTS_PRESENT: r_cfg.fonts_present <= pwdata[2:0];
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_WRAP_ENABLE:   prdata = {31'd0, r_cfg.wrap_enable};
            REG_X_LIMIT:       prdata = {22'd0, r_cfg.x_limit};
            REG_Y_LIMIT:       prdata = {22'd0, r_cfg.y_limit};
            REG_FONTS_PRESENT: prdata = {29'd0, r_cfg.fonts_present};
            default:           prdata = '0;
        endcase
    end

endmodule

// File: rtl/core/tcga_kanji.sv
// Shift-JIS lead/trail pair to kuten glyph offset, with undefined-area rejection.
module tcga_kanji
    import tcga_pkg::*;
#(
    parameter int CHAR_HEIGHT = DEF_CHAR_HEIGHT
) (
    input  logic [7:0]             i_lead,
    input  logic [7:0]             i_trail,
    output logic                   o_valid,
    output logic [GLYPH_OFF_W-1:0] o_offset
);

    logic [7:0]  row_base;
    logic [5:0]  row6;
    logic [7:0]  col8;
    logic        upper_half;
    logic [6:0]  col7;
    logic [6:0]  row7;
    logic [6:0]  row_map;
    logic [12:0] glyph_idx;
    logic [17:0] off_full;
    logic        code_ok;
    logic        undefined;

    always_comb begin
        code_ok  = (i_lead inside {[LEAD1_FIRST:LEAD1_LAST], [LEAD2_FIRST:LEAD2_LAST]}) &&
                   (i_trail inside {[TRAIL_FIRST:TRAIL_LAST]});
        row_base = (i_lead <= LEAD1_LAST) ? (i_lead - LEAD1_FIRST) : (i_lead - LEAD2_BASE);
        row6     = row_base[5:0];
        col8     = i_trail - TRAIL_FIRST - {7'd0, (i_trail > TRAIL_GAP)};
        // second half of a lead byte's 188 codes is the odd kuten row
        upper_half = col8 >= KU_HALF;
        col7       = upper_half ? 7'(col8 - KU_HALF) : col8[6:0];
        row7       = {row6, upper_half};

        undefined = (row7 inside {[7'd8:7'd11], [7'd13:7'd14]}) ||
                    (row7 == KU_LAST_ROW && col7 > 7'd5) || (row7 > KU_LAST_ROW);

        if (row7 inside {[7'd8:7'd12]}) begin
            row_map = row7 - 7'd4;
        end else if (row7 >= 7'd15) begin
            row_map = row7 - 7'd6;
        end else begin
            row_map = row7;
        end

        glyph_idx = 13'(row_map * KU_PER_ROW) + {6'd0, col7};
        off_full  = 18'(glyph_idx * CHAR_HEIGHT);
        o_valid   = code_ok && !undefined;
        o_offset  = off_full[GLYPH_OFF_W-1:0];
    end

endmodule

// File: rtl/core/tcga_cursor.sv
// Cursor, lead-byte and count state with the per-byte classification logic.
module tcga_cursor
    import tcga_pkg::*;
#(
    parameter int CHAR_HEIGHT = DEF_CHAR_HEIGHT,
    parameter int CHAR_WIDTH  = DEF_CHAR_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_advance,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    localparam logic [15:0] STEP_Y = 16'(2 * CHAR_HEIGHT);
    localparam logic [15:0] STEP_X = 16'(2 * CHAR_WIDTH);

    logic signed [15:0] r_cursor_x, r_cursor_y, r_saved_x, r_saved_y;
    logic signed [15:0] r_lead_pos_x, r_lead_pos_y;
    logic               r_resume_mode, r_lead_pending;
    logic [7:0]         r_lead_byte;
    logic [15:0]        r_count;

    logic signed [15:0] n_cursor_x, n_cursor_y, n_saved_x, n_saved_y;
    logic signed [15:0] n_lead_pos_x, n_lead_pos_y;
    logic               n_resume_mode, n_lead_pending;
    logic [7:0]         n_lead_byte;
    logic [15:0]        n_count;

    logic                   kj_valid;
    logic [GLYPH_OFF_W-1:0] kj_offset;

    tcga_kanji #(
        .CHAR_HEIGHT (CHAR_HEIGHT)
    ) u_kanji (
        .i_lead   (r_lead_byte),
        .i_trail  (i_item.text_byte),
        .o_valid  (kj_valid),
        .o_offset (kj_offset)
    );

    always_comb begin
        logic [7:0] c;
        logic       wrap;
        logic       pending;
        logic       skip;
        logic       is_nl;

        c       = i_item.text_byte;
        wrap    = i_cfg.wrap_enable;
        is_nl   = (c == CH_NEWLINE);
        skip    = 1'b0;

        n_cursor_x     = r_cursor_x;
        n_cursor_y     = r_cursor_y;
        n_saved_x      = r_saved_x;
        n_saved_y      = r_saved_y;
        n_resume_mode  = r_resume_mode;
        n_lead_byte    = r_lead_byte;
        n_lead_pos_x   = r_lead_pos_x;
        n_lead_pos_y   = r_lead_pos_y;
        n_count        = r_count;
        pending        = r_lead_pending;
        n_lead_pending = 1'b0;
        o_result       = '0;
        o_result.end_of_string = i_item.last_byte;

        if (i_item.first_byte) begin
            n_count = '0;
            pending = 1'b0;
            if (i_item.start_x == -16'sd1 && i_item.start_y == -16'sd1) begin
                n_cursor_x    = r_saved_x;
                n_cursor_y    = r_saved_y;
                n_resume_mode = 1'b1;
            end else begin
                n_cursor_x    = i_item.start_x;
                n_cursor_y    = i_item.start_y;
                n_resume_mode = 1'b0;
            end
        end

        if (pending) begin
            // trail byte: emit the held kanji at the lead's position
            o_result.draw  = 1'b1;
            o_result.pos_x = r_lead_pos_x;
            o_result.pos_y = r_lead_pos_y;
            if (kj_valid) begin
                o_result.glyph_source = SRC_KANJI;
                o_result.glyph_offset = kj_offset;
            end else begin
                o_result.glyph_source = SRC_MISSING;
            end
        end else begin
            if (n_count != 16'hFFFF) begin
                n_count = n_count + 16'd1;
            end
            if ((wrap && over_limit(n_cursor_x, i_cfg.x_limit)) || is_nl) begin
                n_cursor_y = sat_add16(n_cursor_y, STEP_Y);
                n_cursor_x = '0;
            end
            if (wrap && over_limit(n_cursor_y, i_cfg.y_limit)) begin
                n_cursor_y = '0;
            end
            skip = is_nl || n_cursor_x[15] || n_cursor_y[15] ||
                   (!wrap && (over_limit(n_cursor_x, i_cfg.x_limit) ||
                              over_limit(n_cursor_y, i_cfg.y_limit)));
            if (!skip) begin
                if (c < ASCII_END) begin
                    o_result.draw = 1'b1;
                    if (i_cfg.fonts_present[FONT_ASCII]) begin
                        o_result.glyph_source = SRC_ASCII;
                        o_result.glyph_offset = GLYPH_OFF_W'(c * CHAR_HEIGHT);
                    end else begin
                        o_result.glyph_source = SRC_MISSING;
                    end
                end else if (c inside {[KANA_FIRST:KANA_LAST]}) begin
                    o_result.draw = 1'b1;
                    if (i_cfg.fonts_present[FONT_KANA]) begin
                        o_result.glyph_source = SRC_KANA;
                        o_result.glyph_offset = GLYPH_OFF_W'((c - KANA_FIRST) * CHAR_HEIGHT);
                    end else begin
                        o_result.glyph_source = SRC_MISSING;
                    end
                end else if (i_cfg.fonts_present[FONT_KANJI] && !i_item.last_byte) begin
                    n_lead_pending = 1'b1;
                    n_lead_byte    = c;
                    n_lead_pos_x   = n_cursor_x;
                    n_lead_pos_y   = n_cursor_y;
                end else begin
                    o_result.draw         = 1'b1;
                    o_result.glyph_source = SRC_MISSING;
                end
                if (o_result.draw) begin
                    o_result.pos_x = n_cursor_x;
                    o_result.pos_y = n_cursor_y;
                end
                n_cursor_x = sat_add16(n_cursor_x, STEP_X);
            end
        end

        if (i_item.last_byte && n_resume_mode) begin
            n_saved_x = n_cursor_x;
            n_saved_y = n_cursor_y;
        end

        o_result.char_count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x     <= '0;
            r_cursor_y     <= '0;
            r_saved_x      <= '0;
            r_saved_y      <= '0;
            r_resume_mode  <= 1'b0;
            r_lead_byte    <= '0;
            r_lead_pending <= 1'b0;
            r_lead_pos_x   <= '0;
            r_lead_pos_y   <= '0;
            r_count        <= '0;
        end else if (i_advance) begin
            r_cursor_x     <= n_cursor_x;
            r_cursor_y     <= n_cursor_y;
            r_saved_x      <= n_saved_x;
            r_saved_y      <= n_saved_y;
            r_resume_mode  <= n_resume_mode;
            r_lead_byte    <= n_lead_byte;
            r_lead_pending <= n_lead_pending;
            r_lead_pos_x   <= n_lead_pos_x;
            r_lead_pos_y   <= n_lead_pos_y;
            r_count        <= n_count;
        end
    end

endmodule

// File: rtl/core/text_cursor_glyph_address.sv
// Top level: input register, cursor/glyph logic and result register with APB settings.
//
//  Channel   Direction  Handshake                     Payload
//  -------   ---------  ----------------------------  ----------------------
//  in        sink       i_in_valid / o_in_stall       i_item   (t_in_item)
//  out       source     o_out_valid / i_out_stall     o_result (t_out_item)
//  cfg       APB slave  psel penable pwrite pready    paddr pwdata prdata
//
//  Throughput is one transaction per cycle while the output is not stalled; a result
//  passes through the input register, then the result register.
//  The cursor state updates as an item moves from the input to the result
//  register, so the next item in the input register already works from it.
//  A stalled result holds in the result register; the input register keeps
//  filling, and o_in_stall rises only when both registers are occupied.
//  Synchronous active-low reset empties both registers and clears the cursor.
module text_cursor_glyph_address
    import tcga_pkg::*;
#(
    parameter int CHAR_HEIGHT = DEF_CHAR_HEIGHT,
    parameter int CHAR_WIDTH  = DEF_CHAR_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // byte stream in
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_item,
    // glyph results out
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_result,
    // settings
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg      cfg;
    t_in_item  r_in;
    logic      r_in_valid;
    t_out_item r_out;
    logic      r_out_valid;
    t_out_item step_result;
    logic      advance;
    logic      accept;

    // the item in the input register moves on when the result slot frees up
    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    tcga_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tcga_cursor #(
        .CHAR_HEIGHT (CHAR_HEIGHT),
        .CHAR_WIDTH  (CHAR_WIDTH)
    ) u_cursor (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in),
        .i_cfg     (cfg),
        .o_result  (step_result)
    );

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_item;
        end
        if (advance) begin
            r_out <= step_result;
        end
    end

endmodule

// File: rtl/core/tcga_checker.sv
// Port-level checker for the text cursor glyph address block, bound to the top level.
module tcga_checker
    import tcga_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input t_out_item             o_result
);

    // results are empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a stalled transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result))
        else $error("stalled result changed or dropped");

    // no glyph drawn means no font, offset or position
    a_nodraw_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_result.draw |->
            o_result.glyph_source == SRC_ASCII && o_result.glyph_offset == '0 &&
            o_result.pos_x == '0 && o_result.pos_y == '0)
        else $error("non-drawn result carries glyph data");

    // missing glyph has no offset
    a_missing_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result.glyph_source == SRC_MISSING |->
            o_result.draw && o_result.glyph_offset == '0)
        else $error("missing glyph with offset");

    // the input side never stalls while the result side is free
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty result register");

endmodule

bind text_cursor_glyph_address tcga_checker u_tcga_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_result    (o_result)
);
